@@ design/animation_easing_curve_defines.svh @@
// Assertion macros shared by the easing curve block.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef ANIMATION_EASING_CURVE_DEFINES_SVH
`define ANIMATION_EASING_CURVE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/aec_pkg.sv @@
// Package for the animation easing curve block: widths, fixed-point constants,
// mode and register codes, and the control word carried down the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package aec_pkg;

    // Fixed-point scale is 2^SCALE_SHIFT.
    localparam int SCALE_SHIFT = 10;
    localparam int SCALE       = 1 << SCALE_SHIFT;
    localparam int TW          = SCALE_SHIFT + 1;

    // Field and port widths.
    localparam int POS_W = 16;
    localparam int VAL_W = 19;
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;
    localparam int MODE_W = 3;

    // Q10 constants rescaled to the working scale.
    localparam int Q408  = (408 * SCALE) / 1024;
    localparam int Q614  = (614 * SCALE) / 1024;
    localparam int Q819  = (819 * SCALE) / 1024;
    localparam int Q921  = (921 * SCALE) / 1024;
    localparam int Q2500 = (2500 * SCALE) / 1024;
    localparam int Q50   = (50 * SCALE) / 1024;
    localparam int Q100  = (100 * SCALE) / 1024;
    localparam int Q900  = (900 * SCALE) / 1024;
    localparam int Q950  = (950 * SCALE) / 1024;
    localparam int Q1000 = (1000 * SCALE) / 1024;
    localparam int Q1300 = (1300 * SCALE) / 1024;
    localparam int Q800  = (800 * SCALE) / 1024;
    localparam int Q500  = (500 * SCALE) / 1024;

    // Reciprocal of five, exact for operands below 2^16.
    localparam int RECIP5       = 52429;
    localparam int RECIP5_SHIFT = 18;

    // Curve modes.
    localparam logic [MODE_W-1:0] MODE_STEP      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EASE_IN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EASE_OUT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EASE_IO   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OVERSHOOT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BOUNCE    = 3'd6;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_CURVE_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_IN_START   = 3'd1;
    localparam logic [IDX_W-1:0] REG_IN_END     = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT_START  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUT_END    = 3'd4;

    // Bounce amplitude select.
    localparam logic [1:0] DSEL_FULL = 2'd0;
    localparam logic [1:0] DSEL_20   = 2'd1;
    localparam logic [1:0] DSEL_40   = 2'd2;

    // Per-item control word travelling with the data.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              step_hi;
        logic              clamp;
        logic              clamp_hi;
        logic [1:0]        dsel;
    } aec_ctl_t;

endpackage

@@ design/aec_if.sv @@
// Valid/ready channel interfaces for positions in and eased values out.
// Depends on aec_pkg for the field widths.
`timescale 1ns / 1ps

interface aec_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aec_pkg::POS_W-1:0]       position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface aec_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aec_pkg::VAL_W-1:0]       value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ design/animation_easing_curve.sv @@
// Top level of the animation easing curve evaluator: a deep pipeline with
// a bit-per-stage divider and a staged cubic Bezier evaluator.
// Depends on aec_pkg, aec_if.sv and animation_easing_curve_defines.svh.
`timescale 1ns / 1ps
`include "animation_easing_curve_defines.svh"

// Usage:
// A position arrives on in_ch (valid/ready); one eased value leaves on
// out_ch for each position, in order. The five registers (mode, input
// range, output range) are written through cfg_we/cfg_index/cfg_data
// while no item is in flight; writes to indexes above four are ignored.
// The divider retires one quotient bit per stage, which sets most of the
// pipeline depth.
// Throughput is one item per cycle: a new position can be taken every
// cycle while results are being drained.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and in_ch.ready drops in the same cycle; nothing is
// lost or repeated, and bubbles are carried along as invalid stages.
// Reset clears all stage valid bits and loads the register defaults:
// linear mode, input range 0..1024, output range 0..1024.
module animation_easing_curve (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aec_pkg::IDX_W-1:0]      cfg_index,
    input  logic [aec_pkg::CFG_W-1:0]      cfg_data,
    aec_in_if.sink                         in_ch,
    aec_out_if.source                      out_ch
);

    localparam int SS     = aec_pkg::SCALE_SHIFT;
    localparam int TW     = aec_pkg::TW;
    localparam int DW     = aec_pkg::POS_W;
    localparam int NDIV   = SS;
    localparam int ST_BA  = NDIV + 1;
    localparam int ST_BB  = NDIV + 2;
    localparam int ST_SUM = NDIV + 6;
    localparam int ST_MUL = NDIV + 7;
    localparam int NSTG   = NDIV + 9;
    localparam int BW     = TW + 5;
    localparam int KW     = TW + 1;
    localparam int VW     = TW + 2;
    localparam int STW    = TW + 3;
    localparam int DFW    = DW + 1;
    localparam int PW     = STW + 1 + DFW;
    localparam int P5W    = 30;

    // ---------------------------------------------------------------
    // Configuration registers.
    logic [aec_pkg::MODE_W-1:0] mode_reg;
    logic signed [DW-1:0]       in_start_reg;
    logic signed [DW-1:0]       in_end_reg;
    logic signed [DW-1:0]       out_start_reg;
    logic signed [DW-1:0]       out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= aec_pkg::MODE_LINEAR;
            in_start_reg  <= '0;
            in_end_reg    <= DW'(aec_pkg::SCALE);
            out_start_reg <= '0;
            out_end_reg   <= DW'(aec_pkg::SCALE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aec_pkg::REG_CURVE_MODE: mode_reg      <= cfg_data[aec_pkg::MODE_W-1:0];
                aec_pkg::REG_IN_START:   in_start_reg  <= cfg_data;
                aec_pkg::REG_IN_END:     in_end_reg    <= cfg_data;
                aec_pkg::REG_OUT_START:  out_start_reg <= cfg_data;
                aec_pkg::REG_OUT_END:    out_end_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output span and its truncated twentieth and fortieth, derived from
    // the registers; they settle long before an item needs them.
    logic signed [DFW-1:0] diff_reg;
    logic                  dneg_reg;
    logic [DW-1:0]         dmag_reg;
    logic signed [DFW-1:0] d20_reg;
    logic signed [DFW-1:0] d40_reg;
    logic signed [DFW-1:0] diff_next;
    logic signed [DFW-1:0] dabs;
    logic [P5W-1:0]        p20;
    logic [P5W-1:0]        p40;
    logic signed [DFW-1:0] q20;
    logic signed [DFW-1:0] q40;

    always_comb
    begin
        diff_next = DFW'(out_end_reg) - DFW'(out_start_reg);
        dabs      = diff_reg[DFW-1] ? -diff_reg : diff_reg;
        p20 = P5W'(dmag_reg[DW-1:2]) * P5W'(aec_pkg::RECIP5);
        p40 = P5W'(dmag_reg[DW-1:3]) * P5W'(aec_pkg::RECIP5);
        q20 = $signed(DFW'(p20[P5W-1:aec_pkg::RECIP5_SHIFT]));
        q40 = $signed(DFW'(p40[P5W-1:aec_pkg::RECIP5_SHIFT]));
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        dneg_reg <= diff_reg[DFW-1];
        dmag_reg <= dabs[DW-1:0];
        d20_reg  <= dneg_reg ? -q20 : q20;
        d40_reg  <= dneg_reg ? -q40 : q40;
    end

    // ---------------------------------------------------------------
    // Pipeline control: one stall signal freezes every stage.
    logic [NSTG-1:0] vld_reg;
    logic            st_en;

    assign st_en       = !vld_reg[NSTG-1] || out_ch.ready;
    assign in_ch.ready = st_en;
    assign out_ch.valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (st_en)
            vld_reg <= {vld_reg[NSTG-2:0], in_ch.valid};
    end

    // ---------------------------------------------------------------
    // Input stage: clamp decision, step threshold, divider operands.
    aec_pkg::aec_ctl_t     ctl_in;
    logic signed [DFW-1:0] x17;
    logic signed [DFW-1:0] a17;
    logic signed [DFW-1:0] b17;
    logic signed [DFW-1:0] num17;
    logic signed [DFW-1:0] den17;
    logic signed [DFW-1:0] th_sum;
    logic signed [DFW-1:0] th17;
    logic signed [DFW-1:0] num_abs;
    logic signed [DFW-1:0] den_abs;
    logic                  asc;
    logic                  desc;

    always_comb
    begin
        x17   = DFW'(in_ch.position);
        a17   = DFW'(in_start_reg);
        b17   = DFW'(in_end_reg);
        num17 = x17 - a17;
        den17 = b17 - a17;
        asc   = b17 >= a17;
        desc  = b17 <= a17;
        // Half the span, truncated toward zero; compared against the raw position.
        th_sum = den17 + $signed({{(DFW-1){1'b0}}, den17[DFW-1]});
        th17   = th_sum >>> 1;
        ctl_in.mode     = mode_reg;
        ctl_in.step_hi  = !(x17 < th17);
        ctl_in.dsel     = aec_pkg::DSEL_FULL;
        ctl_in.clamp    = 1'b1;
        ctl_in.clamp_hi = 1'b0;
        priority if (asc && x17 >= b17)
            ctl_in.clamp_hi = 1'b1;
        else if (asc && x17 <= a17)
            ctl_in.clamp_hi = 1'b0;
        else if (desc && x17 <= b17)
            ctl_in.clamp_hi = 1'b1;
        else if (desc && x17 >= a17)
            ctl_in.clamp_hi = 1'b0;
        else
            ctl_in.clamp = 1'b0;
        // Inside the range both differences share a sign.
        num_abs = den17[DFW-1] ? -num17 : num17;
        den_abs = den17[DFW-1] ? -den17 : den17;
    end

    // ---------------------------------------------------------------
    // Restoring divider, one quotient bit per stage.
    logic [DW-1:0]   rem_reg [0:NDIV];
    logic [DW-1:0]   den_reg [0:NDIV];
    logic [NDIV-1:0] q_reg   [0:NDIV];
    logic [DW-1:0]   rem_nx  [1:NDIV];
    logic [NDIV-1:0] q_nx    [1:NDIV];

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        logic [DW:0] sh;
        logic [DW:0] sub;
        logic        fit;

        assign sh  = {rem_reg[k], 1'b0};
        assign sub = sh - {1'b0, den_reg[k]};
        assign fit = sh >= {1'b0, den_reg[k]};
        assign rem_nx[k+1] = fit ? sub[DW-1:0] : sh[DW-1:0];
        assign q_nx[k+1]   = {q_reg[k][NDIV-2:0], fit};
    end

    // Control word shift line; the bounce amplitude select is filled in
    // once the segment is known.
    aec_pkg::aec_ctl_t ctl_reg [0:ST_MUL];
    aec_pkg::aec_ctl_t ctl_ba;
    logic [1:0]        dsel_ba;

    always_comb
    begin
        ctl_ba      = ctl_reg[ST_BA-1];
        ctl_ba.dsel = dsel_ba;
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            ctl_reg[0] <= ctl_in;
            rem_reg[0] <= num_abs[DW-1:0];
            den_reg[0] <= den_abs[DW-1:0];
            q_reg[0]   <= '0;
            for (int i = 1; i <= NDIV; i++)
            begin
                rem_reg[i] <= rem_nx[i];
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_nx[i];
            end
            for (int i = 1; i <= ST_MUL; i++)
            begin
                if (i == ST_BA)
                    ctl_reg[i] <= ctl_ba;
                else
                    ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Bounce stage A: pick the segment and form the first-segment product.
    logic [TW-1:0]        t_div;
    logic [2:0]           bseg;
    logic [TW-1:0]        t_ba_reg;
    logic [2*TW+1:0]      p2500_ba_reg;
    logic [2:0]           bseg_ba_reg;

    always_comb
    begin
        if (ctl_reg[NDIV].clamp)
            t_div = ctl_reg[NDIV].clamp_hi ? TW'(aec_pkg::SCALE) : '0;
        else
            t_div = {1'b0, q_reg[NDIV]};
        priority if (t_div < TW'(aec_pkg::Q408))
            bseg = 3'd0;
        else if (t_div < TW'(aec_pkg::Q614))
            bseg = 3'd1;
        else if (t_div < TW'(aec_pkg::Q819))
            bseg = 3'd2;
        else if (t_div < TW'(aec_pkg::Q921))
            bseg = 3'd3;
        else if (t_div < TW'(aec_pkg::SCALE))
            bseg = 3'd4;
        else
            bseg = 3'd5;
        unique case (bseg)
            3'd1, 3'd2: dsel_ba = aec_pkg::DSEL_20;
            3'd3, 3'd4: dsel_ba = aec_pkg::DSEL_40;
            default:    dsel_ba = aec_pkg::DSEL_FULL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            t_ba_reg     <= t_div;
            p2500_ba_reg <= (2*TW+2)'(t_div) * (2*TW+2)'(aec_pkg::Q2500);
            bseg_ba_reg  <= bseg;
        end
    end

    // ---------------------------------------------------------------
    // Bounce stage B: segment-local time, clamped to [0, S].
    logic signed [BW-1:0] tt_s;
    logic signed [BW-1:0] tb_raw;
    logic [TW-1:0]        tb_sel;
    logic [TW-1:0]        tb_reg;

    always_comb
    begin
        tt_s = $signed(BW'(t_ba_reg));
        unique case (bseg_ba_reg)
            3'd0: tb_raw = $signed(BW'(p2500_ba_reg >> SS));
            3'd1: tb_raw = BW'(aec_pkg::SCALE) - (tt_s - BW'(aec_pkg::Q408)) * BW'(5);
            3'd2: tb_raw = (tt_s - BW'(aec_pkg::Q614)) * BW'(5);
            3'd3: tb_raw = BW'(aec_pkg::SCALE) - (tt_s - BW'(aec_pkg::Q819)) * BW'(10);
            3'd4: tb_raw = (tt_s - BW'(aec_pkg::Q921)) * BW'(10);
            default: tb_raw = tt_s;
        endcase
        if (ctl_reg[ST_BA].mode != aec_pkg::MODE_BOUNCE)
            tb_sel = t_ba_reg;
        else if (tb_raw < 0)
            tb_sel = '0;
        else if (tb_raw > BW'(aec_pkg::SCALE))
            tb_sel = TW'(aec_pkg::SCALE);
        else
            tb_sel = tb_raw[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
            tb_reg <= tb_sel;
    end

    // ---------------------------------------------------------------
    // Bezier stage A: squares of t and of 1 - t.
    logic [TW-1:0]   r_za;
    logic [TW-1:0]   r_za_reg;
    logic [TW-1:0]   t_za_reg;
    logic [2*TW-1:0] rr_reg;
    logic [2*TW-1:0] tt_reg;

    assign r_za = TW'(aec_pkg::SCALE) - tb_reg;

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            r_za_reg <= r_za;
            t_za_reg <= tb_reg;
            rr_reg   <= (2*TW)'(r_za) * (2*TW)'(r_za);
            tt_reg   <= (2*TW)'(tb_reg) * (2*TW)'(tb_reg);
        end
    end

    // ---------------------------------------------------------------
    // Bezier stage B: cubes and the mixed products.
    logic [TW-1:0]   r2;
    logic [TW-1:0]   t2;
    logic [TW-1:0]   t_zb_reg;
    logic [2*TW-1:0] r3p_reg;
    logic [2*TW-1:0] t3p_reg;
    logic [2*TW-1:0] r2t_reg;
    logic [2*TW-1:0] rt2_reg;

    assign r2 = rr_reg[SS+TW-1:SS];
    assign t2 = tt_reg[SS+TW-1:SS];

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            t_zb_reg <= t_za_reg;
            r3p_reg  <= (2*TW)'(r2) * (2*TW)'(r_za_reg);
            t3p_reg  <= (2*TW)'(t2) * (2*TW)'(t_za_reg);
            r2t_reg  <= (2*TW)'(r2) * (2*TW)'(t_za_reg);
            rt2_reg  <= (2*TW)'(r_za_reg) * (2*TW)'(t2);
        end
    end

    // ---------------------------------------------------------------
    // Bezier stage C: weight the four terms by the mode's control points.
    localparam int ZC = NDIV + 4;
    logic [KW-1:0]      k1;
    logic [KW-1:0]      k2;
    logic               use_u0;
    logic               use_u3;
    logic [2*TW+KW-1:0] w2;
    logic [2*TW+KW-1:0] w3;
    logic [TW-1:0]      t_zc_reg;
    logic [VW-1:0]      v1_reg;
    logic [VW-1:0]      v2_reg;
    logic [VW-1:0]      v3_reg;
    logic [VW-1:0]      v4_reg;

    always_comb
    begin
        use_u0 = 1'b0;
        use_u3 = 1'b1;
        unique case (ctl_reg[ZC].mode)
            aec_pkg::MODE_EASE_IN:
            begin
                k1 = KW'(3 * aec_pkg::Q50);
                k2 = KW'(3 * aec_pkg::Q100);
            end
            aec_pkg::MODE_EASE_OUT:
            begin
                k1 = KW'(3 * aec_pkg::Q900);
                k2 = KW'(3 * aec_pkg::Q950);
            end
            aec_pkg::MODE_EASE_IO:
            begin
                k1 = KW'(3 * aec_pkg::Q50);
                k2 = KW'(3 * aec_pkg::Q950);
            end
            aec_pkg::MODE_OVERSHOOT:
            begin
                k1 = KW'(3 * aec_pkg::Q1000);
                k2 = KW'(3 * aec_pkg::Q1300);
            end
            aec_pkg::MODE_BOUNCE:
            begin
                k1     = KW'(3 * aec_pkg::Q800);
                k2     = KW'(3 * aec_pkg::Q500);
                use_u0 = 1'b1;
                use_u3 = 1'b0;
            end
            default:
            begin
                k1 = '0;
                k2 = '0;
            end
        endcase
        w2 = (2*TW+KW)'(r2t_reg) * (2*TW+KW)'(k1);
        w3 = (2*TW+KW)'(rt2_reg) * (2*TW+KW)'(k2);
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            t_zc_reg <= t_zb_reg;
            v1_reg   <= use_u0 ? VW'(r3p_reg[SS+TW-1:SS]) : '0;
            v4_reg   <= use_u3 ? VW'(t3p_reg[SS+TW-1:SS]) : '0;
            v2_reg   <= w2[2*SS+VW-1:2*SS];
            v3_reg   <= w3[2*SS+VW-1:2*SS];
        end
    end

    // ---------------------------------------------------------------
    // Sum stage: Bezier value, or plain t for the linear modes.
    logic           curve_mode_sum;
    logic [STW-1:0] step_reg;

    always_comb
    begin
        unique case (ctl_reg[ST_SUM - 1].mode)
            aec_pkg::MODE_EASE_IN, aec_pkg::MODE_EASE_OUT, aec_pkg::MODE_EASE_IO,
            aec_pkg::MODE_OVERSHOOT, aec_pkg::MODE_BOUNCE: curve_mode_sum = 1'b1;
            default:                                      curve_mode_sum = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
        begin
            if (curve_mode_sum)
                step_reg <= STW'(v1_reg) + STW'(v2_reg) + STW'(v3_reg) + STW'(v4_reg);
            else
                step_reg <= STW'(t_zc_reg);
        end
    end

    // ---------------------------------------------------------------
    // Multiply stage: scale by the output span (damped for bounce).
    logic signed [DFW-1:0] dmul;
    logic signed [PW-1:0]  prod_reg;

    always_comb
    begin
        if (ctl_reg[ST_SUM].mode != aec_pkg::MODE_BOUNCE)
            dmul = diff_reg;
        else
        begin
            unique case (ctl_reg[ST_SUM].dsel)
                aec_pkg::DSEL_20: dmul = d20_reg;
                aec_pkg::DSEL_40: dmul = d40_reg;
                default:          dmul = diff_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
            prod_reg <= PW'($signed({1'b0, step_reg})) * PW'(dmul);
    end

    // ---------------------------------------------------------------
    // Output: add the base, subtract from the end (bounce), or pick an end (step).
    logic signed [PW-1:0]    sh_out;
    logic signed [PW:0]      res;
    logic [aec_pkg::VAL_W-1:0] value_reg;

    always_comb
    begin
        sh_out = prod_reg >>> SS;
        unique case (ctl_reg[ST_MUL].mode)
            aec_pkg::MODE_STEP:
                res = ctl_reg[ST_MUL].step_hi ? (PW+1)'(out_end_reg)
                                              : (PW+1)'(out_start_reg);
            aec_pkg::MODE_BOUNCE:
                res = (PW+1)'(out_end_reg) - (PW+1)'(sh_out);
            default:
                res = (PW+1)'(sh_out) + (PW+1)'(out_start_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_en)
            value_reg <= res[aec_pkg::VAL_W-1:0];
    end

    assign out_ch.value = value_reg;

    // ---------------------------------------------------------------
    // Checks.
    `AEC_ASSERT_NOW(a_div_rem, vld_reg[NDIV] && !ctl_reg[NDIV].clamp, rem_reg[NDIV] < den_reg[NDIV], "divider remainder not below divisor")
    `AEC_ASSERT_NOW(a_tb_range, vld_reg[ST_BB], tb_reg <= TW'(aec_pkg::SCALE), "eased time above full scale")
    `AEC_ASSERT_NEXT(a_stall_hold, !st_en, $stable(vld_reg), "pipeline moved during a stall")

endmodule

@@ sim/animation_easing_curve_tb.sv @@
// Self-checking testbench for the animation easing curve evaluator.
// Drives positions under many register settings, predicts each eased value
// with its own fixed-point curve model, and checks results in order.
// Depends on aec_pkg, aec_if.sv and the animation_easing_curve RTL.
`timescale 1ns / 1ps

// Holds expected eased values in order and compares results against them.
class easing_scoreboard;
    logic signed [aec_pkg::VAL_W-1:0] pending_values[$];
    int mismatches;
    int checked;

    function new();
        mismatches = 0;
        checked = 0;
    endfunction

    function void note_position(logic signed [aec_pkg::VAL_W-1:0] expected_value);
        pending_values.push_back(expected_value);
    endfunction

    function void check_value(logic signed [aec_pkg::VAL_W-1:0] got);
        logic signed [aec_pkg::VAL_W-1:0] want;
        if (pending_values.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result value %0d", got);
            return;
        end
        want = pending_values.pop_front();
        checked++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: value expected %0d got %0d", want, got);
        end
    endfunction
endclass

module animation_easing_curve_tb;

    localparam int LATENCY = aec_pkg::SCALE_SHIFT + 8;
    localparam longint CYCLE_LIMIT = 400000;
    // Index past the last register; writes to it must change nothing.
    localparam logic [aec_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [aec_pkg::IDX_W-1:0] cfg_index;
    logic [aec_pkg::CFG_W-1:0] cfg_data;

    aec_in_if in_ch ();
    aec_out_if out_ch ();

    animation_easing_curve u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    // Local copy of the configuration registers.
    logic [aec_pkg::MODE_W-1:0] mode_reg;
    longint rng_in_lo, rng_in_hi, rng_out_lo, rng_out_hi;

    easing_scoreboard sb;
    longint cycles;
    int sent;
    int stall_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL animation_easing_curve");
            $finish;
        end
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qc(longint c);
        return (c * (longint'(1) << aec_pkg::SCALE_SHIFT)) / 1024;
    endfunction

    function automatic longint norm_pos(longint x);
        longint full;
        full = longint'(1) << aec_pkg::SCALE_SHIFT;
        if (rng_in_hi >= rng_in_lo && x >= rng_in_hi) return full;
        if (rng_in_hi >= rng_in_lo && x <= rng_in_lo) return 0;
        if (rng_in_hi <= rng_in_lo && x <= rng_in_hi) return full;
        if (rng_in_hi <= rng_in_lo && x >= rng_in_lo) return 0;
        return ((x - rng_in_lo) * full) / (rng_in_hi - rng_in_lo);
    endfunction

    function automatic longint cubic_curve(longint t, longint p0, longint p1,
                                           longint p2, longint p3);
        longint r, r2, r3, t2, t3;
        r = (longint'(1) << aec_pkg::SCALE_SHIFT) - t;
        r2 = shr(r * r, aec_pkg::SCALE_SHIFT);
        r3 = shr(r2 * r, aec_pkg::SCALE_SHIFT);
        t2 = shr(t * t, aec_pkg::SCALE_SHIFT);
        t3 = shr(t2 * t, aec_pkg::SCALE_SHIFT);
        return shr(r3 * p0, aec_pkg::SCALE_SHIFT)
             + shr(3 * r2 * t * p1, 2 * aec_pkg::SCALE_SHIFT)
             + shr(3 * r * t2 * p2, 2 * aec_pkg::SCALE_SHIFT)
             + shr(t3 * p3, aec_pkg::SCALE_SHIFT);
    endfunction

    function automatic longint bounce_value(longint t);
        longint full, span, st;
        full = longint'(1) << aec_pkg::SCALE_SHIFT;
        span = rng_out_hi - rng_out_lo;
        if (t < qc(408))
            t = shr(t * qc(2500), aec_pkg::SCALE_SHIFT);
        else if (t < qc(614))
        begin
            t = full - (t - qc(408)) * 5;
            span = span / 20;
        end
        else if (t < qc(819))
        begin
            t = (t - qc(614)) * 5;
            span = span / 20;
        end
        else if (t < qc(921))
        begin
            t = full - (t - qc(819)) * 10;
            span = span / 40;
        end
        else if (t < full)
        begin
            t = (t - qc(921)) * 10;
            span = span / 40;
        end
        if (t < 0) t = 0;
        if (t > full) t = full;
        st = cubic_curve(t, full, qc(800), qc(500), 0);
        return rng_out_hi - shr(st * span, aec_pkg::SCALE_SHIFT);
    endfunction

    function automatic longint to_out(longint st);
        return shr(st * (rng_out_hi - rng_out_lo), aec_pkg::SCALE_SHIFT) + rng_out_lo;
    endfunction

    // Predicted eased value for one position under the current registers.
    function automatic logic signed [aec_pkg::VAL_W-1:0] eased_value(
        logic signed [aec_pkg::POS_W-1:0] pos);
        longint x, t, r, full;
        x = pos;
        full = longint'(1) << aec_pkg::SCALE_SHIFT;
        t = norm_pos(x);
        case (mode_reg)
            aec_pkg::MODE_STEP:
                r = (x < (rng_in_hi - rng_in_lo) / 2) ? rng_out_lo : rng_out_hi;
            aec_pkg::MODE_EASE_IN:
                r = to_out(cubic_curve(t, 0, qc(50), qc(100), full));
            aec_pkg::MODE_EASE_OUT:
                r = to_out(cubic_curve(t, 0, qc(900), qc(950), full));
            aec_pkg::MODE_EASE_IO:
                r = to_out(cubic_curve(t, 0, qc(50), qc(950), full));
            aec_pkg::MODE_OVERSHOOT:
                r = to_out(cubic_curve(t, 0, qc(1000), qc(1300), full));
            aec_pkg::MODE_BOUNCE:
                r = bounce_value(t);
            default:
                r = to_out(t);
        endcase
        return r[aec_pkg::VAL_W-1:0];
    endfunction

    // Register write; also updates the local copy. The write enable stays
    // high so that writes can follow back to back; end_config drops it.
    task automatic write_reg(logic [aec_pkg::IDX_W-1:0] idx,
                             logic [aec_pkg::CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            aec_pkg::REG_CURVE_MODE: mode_reg = data[aec_pkg::MODE_W-1:0];
            aec_pkg::REG_IN_START: rng_in_lo = longint'($signed(data));
            aec_pkg::REG_IN_END: rng_in_hi = longint'($signed(data));
            aec_pkg::REG_OUT_START: rng_out_lo = longint'($signed(data));
            aec_pkg::REG_OUT_END: rng_out_hi = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic end_config();
        cfg_we <= 1'b0;
    endtask

    task automatic set_curve(logic [aec_pkg::MODE_W-1:0] m, int a, int b, int c, int d);
        write_reg(aec_pkg::REG_CURVE_MODE, aec_pkg::CFG_W'(m));
        write_reg(aec_pkg::REG_IN_START, aec_pkg::CFG_W'(a));
        write_reg(aec_pkg::REG_IN_END, aec_pkg::CFG_W'(b));
        write_reg(aec_pkg::REG_OUT_START, aec_pkg::CFG_W'(c));
        write_reg(aec_pkg::REG_OUT_END, aec_pkg::CFG_W'(d));
        end_config();
    endtask

    // Offers one position and waits for its transfer. Valid stays high
    // after the transfer so that the next item can follow without a gap.
    task automatic send_position(logic signed [aec_pkg::POS_W-1:0] pos, bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.position <= pos;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_position(eased_value(pos));
        sent++;
    endtask

    task automatic drain_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending_values.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic int rand16();
        return int'($signed(16'($urandom)));
    endfunction

    // Random position, often inside or near the input range.
    function automatic logic signed [aec_pkg::POS_W-1:0] pick_position();
        int lo, hi, sel;
        lo = int'((rng_in_lo < rng_in_hi) ? rng_in_lo : rng_in_hi);
        hi = int'((rng_in_lo < rng_in_hi) ? rng_in_hi : rng_in_lo);
        sel = $urandom_range(0, 9);
        if (sel < 6) return aec_pkg::POS_W'($urandom_range(hi - lo, 0) + lo);
        if (sel == 6) return aec_pkg::POS_W'(lo + $urandom_range(0, 4) - 2);
        if (sel == 7) return aec_pkg::POS_W'(hi + $urandom_range(0, 4) - 2);
        return aec_pkg::POS_W'($urandom);
    endfunction

    // Receiver: random ready with one long hold-off while items keep coming.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall_hold) @(posedge clk);
                stall_hold = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_value(out_ch.value);
    end

    initial
    begin
        int phase;
        int n_items;
        logic signed [aec_pkg::POS_W-1:0] edge_pos[6];
        sb = new();
        cycles = 0;
        sent = 0;
        stall_hold = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.position = '0;
        mode_reg = aec_pkg::MODE_LINEAR;
        rng_in_lo = 0;
        rng_in_hi = 1024;
        rng_out_lo = 0;
        rng_out_hi = 1024;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset settings, then each mode over edge positions.
        edge_pos = '{16'sh8000, 16'sh7fff, 0, 512, 1023, 1024};
        foreach (edge_pos[i]) send_position(edge_pos[i], 0);
        drain_idle();
        for (int m = 0; m < 8; m++)
        begin
            set_curve(m[2:0], 0, 1000, -32768, 32767);
            send_position(499, 0);
            send_position(500, 0);
            send_position(1000, 0);
            drain_idle();
        end
        // Empty, descending ranges, the stray register index and bounce at full scale.
        set_curve(aec_pkg::MODE_LINEAR, 100, 100, 5, -5);
        send_position(99, 0);
        send_position(100, 0);
        drain_idle();
        write_reg(REG_UNUSED, 16'hffff);
        set_curve(aec_pkg::MODE_BOUNCE, 32767, -32768, 32767, -32768);
        send_position(-32768, 0);
        send_position(5, 0);
        drain_idle();

        // Random part: phases with new settings each. One phase sends a
        // long burst against a long receiver hold-off so the pipeline fills.
        for (phase = 0; phase < 40; phase++)
        begin
            if (phase % 8 == 7)
                set_curve(3'($urandom_range(0, 7)), -32768, 32767, -32768, 32767);
            else if (phase % 8 == 3)
                set_curve(3'($urandom_range(0, 7)), 32767, -32768, 32767, -32768);
            else
                set_curve(3'($urandom_range(0, 7)), rand16(), rand16(), rand16(), rand16());
            n_items = 15;
            if (phase == 22)
            begin
                stall_hold = 200;
                n_items = 40;
            end
            for (int k = 0; k < n_items; k++)
                send_position(pick_position(), phase % 5 != 2);
            drain_idle();
        end

        $display("Run sent %0d positions across all eight mode codes and %0d checked results.",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending_values.size() == 0)
        begin
            $display("PASS animation_easing_curve");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_values.size());
            $display("FAIL animation_easing_curve");
        end
        $finish;
    end
endmodule
